>>> sv/lpm_pkg.sv
// Package for the longest-prefix-match route table.
// Holds item kind codes, default parameter values and the mask popcount.
// No dependencies.
package lpm_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_PORT_BITS   = 4;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 6;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    function automatic logic [3:0] ones8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    // Four byte counts summed; the widest result is 32, which fits in six bits.
    function automatic logic [LEN_W-1:0] ones32(input logic [ADDR_W-1:0] w);
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
        lo = {2'd0, ones8(w[7:0])} + {2'd0, ones8(w[15:8])};
        hi = {2'd0, ones8(w[23:16])} + {2'd0, ones8(w[31:24])};
        return lo + hi;
    endfunction

endpackage

>>> sv/longest_prefix_match_table_core.sv
// Longest-prefix-match route table: append and lookup over one stored-route memory.
// An append goes to the finishing state and its result; a lookup scans each stored route,
// drains the read and compare stages and finishes; an empty table skips the scan. The read
// port streams one route per cycle into a single shared compare-and-popcount unit, which
// sets the lookup time. One item is in work at a time. Reset clears the route count and
// control state only; the route memory is not cleared and needs no clearing pass.
module longest_prefix_match_table_core
    import lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int PORT_BITS   = DEF_PORT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [ADDR_W-1:0]    route_dest,
    input  logic [ADDR_W-1:0]    route_mask,
    input  logic [ADDR_W-1:0]    route_gateway,
    input  logic [PORT_BITS-1:0] route_port,
    input  logic [ADDR_W-1:0]    lookup_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [ADDR_W-1:0]    next_hop,
    output logic [PORT_BITS-1:0] out_port,
    output logic [LEN_W-1:0]     prefix_length,
    output logic [ADDR_W-1:0]    match_dest,
    output logic                 table_full
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0]    dest_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]    mask_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]    gw_mem   [TABLE_DEPTH];
    logic [PORT_BITS-1:0] port_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [ADDR_W-1:0]    addr_reg;

    // Read stage
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    rd_dest_reg;
    logic [ADDR_W-1:0]    rd_mask_reg;
    logic [ADDR_W-1:0]    rd_gw_reg;
    logic [PORT_BITS-1:0] rd_port_reg;

    // Compare stage
    logic                 cmp_vld_reg;
    logic                 cmp_hit_reg;
    logic [LEN_W-1:0]     cmp_len_reg;
    logic [ADDR_W-1:0]    cmp_dest_reg;
    logic [ADDR_W-1:0]    cmp_gw_reg;
    logic [PORT_BITS-1:0] cmp_port_reg;

    // Running best, which is also the pending result
    logic                 best_found_reg;
    logic [LEN_W-1:0]     best_len_reg;
    logic [ADDR_W-1:0]    best_dest_reg;
    logic [ADDR_W-1:0]    best_gw_reg;
    logic [PORT_BITS-1:0] best_port_reg;
    logic                 full_reg;

    logic                 out_valid_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    next_hop_reg;
    logic [PORT_BITS-1:0] out_port_reg;
    logic [LEN_W-1:0]     prefix_length_reg;
    logic [ADDR_W-1:0]    match_dest_reg;
    logic                 table_full_reg;

    logic in_beat;
    logic has_room;
    logic last_issue;
    logic cmp_hit;
    logic take_best;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_beat    = in_valid && in_ready;
    assign has_room   = (count_reg < CNT_W'(TABLE_DEPTH));
    assign last_issue = (CNT_W'(rd_idx_reg) == (count_reg - CNT_W'(1)));
    assign cmp_hit    = ((addr_reg & rd_mask_reg) == (rd_dest_reg & rd_mask_reg));
    // A strictly longer prefix is needed to replace, so the earliest route wins a tie.
    assign take_best  = cmp_vld_reg && cmp_hit_reg
                        && (!best_found_reg || (cmp_len_reg > best_len_reg));

    always_ff @(posedge clk)
    begin
        if (in_beat && (kind == KIND_APPEND) && has_room)
        begin
            dest_mem[count_reg[IDX_W-1:0]] <= route_dest;
            mask_mem[count_reg[IDX_W-1:0]] <= route_mask;
            gw_mem[count_reg[IDX_W-1:0]]   <= route_gateway;
            port_mem[count_reg[IDX_W-1:0]] <= route_port;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_dest_reg <= dest_mem[rd_idx_reg];
            rd_mask_reg <= mask_mem[rd_idx_reg];
            rd_gw_reg   <= gw_mem[rd_idx_reg];
            rd_port_reg <= port_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= (state_reg == ST_SCAN);
            cmp_vld_reg  <= rd_vld_reg;
            cmp_hit_reg  <= cmp_hit;
            cmp_len_reg  <= ones32(rd_mask_reg);
            cmp_dest_reg <= rd_dest_reg;
            cmp_gw_reg   <= rd_gw_reg;
            cmp_port_reg <= rd_port_reg;

            if (take_best)
            begin
                best_found_reg <= 1'b1;
                best_len_reg   <= cmp_len_reg;
                best_dest_reg  <= cmp_dest_reg;
                best_gw_reg    <= cmp_gw_reg;
                best_port_reg  <= cmp_port_reg;
            end

            // In the finishing state the result load below decides the output valid.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        best_found_reg <= 1'b0;
                        best_len_reg   <= '0;
                        best_dest_reg  <= '0;
                        best_gw_reg    <= '0;
                        best_port_reg  <= '0;
                        addr_reg       <= lookup_address;
                        rd_idx_reg     <= '0;
                        if (kind == KIND_APPEND)
                        begin
                            full_reg  <= !has_room;
                            state_reg <= ST_FINISH;
                            if (has_room)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            full_reg  <= 1'b0;
                            state_reg <= (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // The last compare has updated the best once both stages are empty.
                    if (!rd_vld_reg && !cmp_vld_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        found_reg         <= best_found_reg;
                        next_hop_reg      <= best_gw_reg;
                        out_port_reg      <= best_port_reg;
                        prefix_length_reg <= best_len_reg;
                        match_dest_reg    <= best_dest_reg;
                        table_full_reg    <= full_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign next_hop      = next_hop_reg;
    assign out_port      = out_port_reg;
    assign prefix_length = prefix_length_reg;
    assign match_dest    = match_dest_reg;
    assign table_full    = table_full_reg;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready after taking an input beat");

    a_full_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && table_full))
        else $error("result flags both a match and a dropped append");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (next_hop == '0) && (prefix_length == '0)
                                && (match_dest == '0) && (out_port == '0))
        else $error("result without a match carries non-zero route fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("route count exceeds table depth");

endmodule

>>> test/lpm_scoreboard.sv
`timescale 1ns / 1ps
// Checker for the longest-prefix-match route table: watches both channels and keeps its
// own copy of the route table. It compares every result beat with the oldest prediction.
// Depends on lpm_pkg for widths, defaults and item kind codes.
module lpm_scoreboard
    import lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int PORT_BITS   = DEF_PORT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 kind,
    input  logic [ADDR_W-1:0]    route_dest,
    input  logic [ADDR_W-1:0]    route_mask,
    input  logic [ADDR_W-1:0]    route_gateway,
    input  logic [PORT_BITS-1:0] route_port,
    input  logic [ADDR_W-1:0]    lookup_address,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 found,
    input  logic [ADDR_W-1:0]    next_hop,
    input  logic [PORT_BITS-1:0] out_port,
    input  logic [LEN_W-1:0]     prefix_length,
    input  logic [ADDR_W-1:0]    match_dest,
    input  logic                 table_full,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct {
        logic                 found;
        logic [ADDR_W-1:0]    next_hop;
        logic [PORT_BITS-1:0] out_port;
        logic [LEN_W-1:0]     prefix_length;
        logic [ADDR_W-1:0]    match_dest;
        logic                 table_full;
    } route_answer_t;

    logic [ADDR_W-1:0]    net_tbl  [TABLE_DEPTH];
    logic [ADDR_W-1:0]    mask_tbl [TABLE_DEPTH];
    logic [ADDR_W-1:0]    gw_tbl   [TABLE_DEPTH];
    logic [PORT_BITS-1:0] port_tbl [TABLE_DEPTH];
    int                   routes_held;
    route_answer_t        answers_due[$];
    int                   error_total;

    function automatic logic [LEN_W-1:0] mask_ones(input logic [ADDR_W-1:0] m);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int b = 0; b < ADDR_W; b++)
        begin
            n = n + LEN_W'(m[b]);
        end
        return n;
    endfunction

    // Applies one item to the shadow table and returns the answer the block should give.
    function automatic route_answer_t route_answer(input logic op,
                                                   input logic [ADDR_W-1:0] dst,
                                                   input logic [ADDR_W-1:0] msk,
                                                   input logic [ADDR_W-1:0] gw,
                                                   input logic [PORT_BITS-1:0] prt,
                                                   input logic [ADDR_W-1:0] addr);
        route_answer_t    r;
        logic [LEN_W-1:0] len;
        r = '{default: '0};
        if (op == KIND_APPEND)
        begin
            if (routes_held < TABLE_DEPTH)
            begin
                net_tbl[routes_held]  = dst;
                mask_tbl[routes_held] = msk;
                gw_tbl[routes_held]   = gw;
                port_tbl[routes_held] = prt;
                routes_held++;
            end
            else
            begin
                r.table_full = 1'b1;
            end
        end
        else
        begin
            // Scan in load order; only a strictly longer mask displaces the current winner.
            for (int i = 0; i < routes_held; i++)
            begin
                if (((addr ^ net_tbl[i]) & mask_tbl[i]) == '0)
                begin
                    len = mask_ones(mask_tbl[i]);
                    if (!r.found || len > r.prefix_length)
                    begin
                        r.found         = 1'b1;
                        r.prefix_length = len;
                        r.next_hop      = gw_tbl[i];
                        r.out_port      = port_tbl[i];
                        r.match_dest    = net_tbl[i];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        route_answer_t want;
        int            bad;
        if (!rst_n)
        begin
            routes_held = 0;
            answers_due.delete();
            error_total = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // The result side is handled first, so a beat can never be matched against
            // an item accepted on the same edge.
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result beat arrived with no prediction waiting");
                    error_total++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    bad = field_differs("found", 32'(want.found), 32'(found))
                        + field_differs("next_hop", want.next_hop, next_hop)
                        + field_differs("out_port", 32'(want.out_port), 32'(out_port))
                        + field_differs("prefix_length", 32'(want.prefix_length),
                                        32'(prefix_length))
                        + field_differs("match_dest", want.match_dest, match_dest)
                        + field_differs("table_full", 32'(want.table_full),
                                        32'(table_full));
                    error_total += bad;
                end
            end
            if (in_valid && in_ready)
            begin
                answers_due.insert(answers_due.size(),
                                   route_answer(kind, route_dest, route_mask,
                                                route_gateway, route_port,
                                                lookup_address));
            end
            mismatches  <= error_total;
            outstanding <= answers_due.size();
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top of the route table testbench: clock, reset, stimulus, result-side stalls and verdict.
// Depends on lpm_pkg, longest_prefix_match_table_core and lpm_scoreboard.
module tb;
    import lpm_pkg::*;

    localparam int PORT_BITS      = DEF_PORT_BITS;
    localparam int RANDOM_ITEMS   = 730;
    localparam int DRAIN_EVERY    = 250;
    localparam int TAIL_CYCLES    = DEF_TABLE_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 kind           = KIND_APPEND;
    logic [ADDR_W-1:0]    route_dest     = '0;
    logic [ADDR_W-1:0]    route_mask     = '0;
    logic [ADDR_W-1:0]    route_gateway  = '0;
    logic [PORT_BITS-1:0] route_port     = '0;
    logic [ADDR_W-1:0]    lookup_address = '0;
    logic                 out_ready      = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 found;
    logic [ADDR_W-1:0]    next_hop;
    logic [PORT_BITS-1:0] out_port;
    logic [LEN_W-1:0]     prefix_length;
    logic [ADDR_W-1:0]    match_dest;
    logic                 table_full;
    int                   mismatches;
    int                   outstanding;

    logic [ADDR_W-1:0]    sent_dest[$];
    logic [ADDR_W-1:0]    sent_mask[$];
    int                   idle_cycles = 0;
    int                   sink_mode   = 0;
    int                   mode_left   = 0;
    int                   stall_left  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    longest_prefix_match_table_core #(
        .TABLE_DEPTH (DEF_TABLE_DEPTH),
        .PORT_BITS   (PORT_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .route_dest     (route_dest),
        .route_mask     (route_mask),
        .route_gateway  (route_gateway),
        .route_port     (route_port),
        .lookup_address (lookup_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .next_hop       (next_hop),
        .out_port       (out_port),
        .prefix_length  (prefix_length),
        .match_dest     (match_dest),
        .table_full     (table_full)
    );

    lpm_scoreboard #(
        .TABLE_DEPTH (DEF_TABLE_DEPTH),
        .PORT_BITS   (PORT_BITS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .route_dest     (route_dest),
        .route_mask     (route_mask),
        .route_gateway  (route_gateway),
        .route_port     (route_port),
        .lookup_address (lookup_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .next_hop       (next_hop),
        .out_port       (out_port),
        .prefix_length  (prefix_length),
        .match_dest     (match_dest),
        .table_full     (table_full),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
        return (len == 0) ? '0 : ~32'd0 << (ADDR_W - len);
    endfunction

    // Holds the beat on the bus until it is taken; valid is left high for the caller.
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] dst,
                             input logic [ADDR_W-1:0] msk, input logic [ADDR_W-1:0] gw,
                             input logic [PORT_BITS-1:0] prt,
                             input logic [ADDR_W-1:0] addr);
        in_valid       <= 1'b1;
        kind           <= op;
        route_dest     <= dst;
        route_mask     <= msk;
        route_gateway  <= gw;
        route_port     <= prt;
        lookup_address <= addr;
        if (op == KIND_APPEND)
        begin
            sent_dest.insert(sent_dest.size(), dst);
            sent_mask.insert(sent_mask.size(), msk);
        end
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle_for(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Mostly lookups aimed at stored routes, over routes drawn near earlier ones so that
    // prefixes overlap and equal-length ties occur.
    task automatic send_random_item();
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] msk;
        logic [ADDR_W-1:0] addr;
        int                pick;
        int                sel;
        sel  = $urandom_range(0, 99);
        dst  = $urandom;
        msk  = $urandom;
        addr = $urandom;
        pick = (sent_dest.size() == 0) ? -1 : $urandom_range(0, sent_dest.size() - 1);
        if (sel < 30)
        begin
            if ($urandom_range(0, 99) < 70)
                msk = prefix_mask($urandom_range(0, 32));
            else if (pick >= 0 && $urandom_range(0, 1) == 1)
                msk = sent_mask[pick];
            if (pick >= 0 && $urandom_range(0, 1) == 1)
                dst = (sent_dest[pick] & prefix_mask($urandom_range(0, 32)))
                    | (dst & ~prefix_mask($urandom_range(0, 32)));
            send_item(KIND_APPEND, dst, msk, $urandom,
                      PORT_BITS'($urandom_range(0, 15)), addr);
        end
        else
        begin
            if (pick >= 0 && sel < 80)
                addr = (sent_dest[pick] & sent_mask[pick]) | (addr & ~sent_mask[pick]);
            else if (pick >= 0 && sel < 88)
                addr = sent_dest[pick];
            send_item(KIND_LOOKUP, $urandom, $urandom, $urandom,
                      PORT_BITS'($urandom_range(0, 15)), addr);
        end
    endtask

    // Result side: a few stall patterns, each held for a random stretch of cycles.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(64, 256);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_mode == 3 && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(5, 30);
        end
        else if (sink_mode == 1)
        begin
            out_ready <= 1'($urandom_range(0, 1));
        end
        else if (sink_mode == 2)
        begin
            out_ready <= ($urandom_range(0, 3) == 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int burst;
        int done;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookups on an empty table.
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'h0000_0000);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF);
        // Two identical /24 routes: the earlier one must win the tie. The destination
        // carries host bits that the mask must hide.
        send_item(KIND_APPEND, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0A00_0001, 4'd1, '0);
        send_item(KIND_APPEND, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0002, 4'd2, '0);
        idle_for(3);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'h0A00_0000);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_0155);
        // Host route, default route, a /16 and a non-contiguous mask.
        send_item(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0, '0);
        send_item(KIND_APPEND, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15, '0);
        send_item(KIND_APPEND, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0003, 4'd3, '0);
        send_item(KIND_APPEND, 32'h1234_5678, 32'hF0F0_F0F0, 32'h0A00_0004, 4'd4, '0);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_0105);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hC0A8_FF01);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFE);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'h1F3F_5F7F);
        send_item(KIND_LOOKUP, '0, '0, '0, '0, 32'h0000_0000);
        hold_until_drained();

        // The table fills part way through; later appends are dropped and flagged.
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && done < RANDOM_ITEMS; k++)
            begin
                send_random_item();
                done++;
                if (done % DRAIN_EVERY == 0)
                    hold_until_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
